FILE: src/ecal_pkg.sv
`timescale 1ns / 1ps
// Package for the epoch-seconds to calendar converter: widths, constants,
// status and sequencer types, month length table. No dependencies.
package ecal_pkg;

  localparam int EPOCH_W       = 34;
  localparam int BIAS_W        = 18;
  localparam int T_W           = 35;   // adjusted time, never negative when used
  localparam int YEAR_W        = 12;
  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 5;
  localparam int HOUR_W        = 5;
  localparam int MIN_W         = 6;
  localparam int SEC_W         = 6;
  localparam int MSEC_W        = 22;   // seconds in one month
  localparam int YEAR_SPAN_DEF = 256;

  localparam logic [YEAR_W-1:0]  BASE_YEAR     = 12'd1970;
  localparam logic [6:0]         BASE_MOD100   = 7'd70;
  localparam logic [8:0]         BASE_MOD400   = 9'd370;
  localparam logic [T_W-1:0]     SECS_DAY      = 35'd86400;
  localparam logic [T_W-1:0]     SECS_HOUR     = 35'd3600;
  localparam logic [T_W-1:0]     SECS_MIN      = 35'd60;
  localparam logic [T_W-1:0]     SECS_YEAR     = 35'd31536000;
  localparam logic [T_W-1:0]     SECS_LEAPYEAR = 35'd31622400;
  localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd11;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BEFORE = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_DONE
  } state_t;

  // Seconds in a month; February takes 29 days in a leap year.
  function automatic logic [MSEC_W-1:0] month_secs(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
    logic [MSEC_W-1:0] s;
    case (m)
      4'd1:    s = leap ? 22'd2505600 : 22'd2419200;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   s = 22'd2592000;
      default: s = 22'd2678400;
    endcase
    return s;
  endfunction

endpackage

FILE: src/ecal_sub_unit.sv
`timescale 1ns / 1ps
// Shared subtract-and-compare unit of the calendar converter.
// Depends on nothing; width comes from the parent.
module ecal_sub_unit #(
  parameter int W = 35
) (
  input  logic [W-1:0] minuend,
  input  logic [W-1:0] subtrahend,
  output logic [W-1:0] diff,
  output logic         ge
);
  logic borrow;

  assign {borrow, diff} = {1'b0, minuend} - {1'b0, subtrahend};
  assign ge             = ~borrow;
endmodule

FILE: src/epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// Top level of the epoch-seconds to Gregorian calendar converter.
// Depends on ecal_pkg and ecal_sub_unit.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | start, busy, in_epoch_seconds           | taken when start & !busy
//  result  | out_valid, out_year .. out_status       | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_utc_bias_...  | written when valid & ready
//
// The sequencer takes off in turn whole years passed (at most YEAR_SPAN - 1),
// whole months (<= 11), whole days (<= 30), whole hours (<= 23) and whole
// minutes (<= 59); the rest is the seconds. One shared subtract/compare unit
// takes one step per cycle; each stage ends on the step whose compare fails,
// the month stage also at the last month. An item before the epoch after bias
// goes straight to done; one beyond the span ends in the year stage.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears
// the bias to 0. The result strobe lasts exactly one cycle; the receiver
// cannot stall it, and busy stays high until that cycle ends.
module epoch_seconds_to_calendar_unit #(
  parameter int YEAR_SPAN = ecal_pkg::YEAR_SPAN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [ecal_pkg::EPOCH_W-1:0]  in_epoch_seconds,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic signed [ecal_pkg::BIAS_W-1:0] cfg_utc_bias_seconds,
  // result channel
  output logic                          out_valid,
  output logic [ecal_pkg::YEAR_W-1:0]   out_year,
  output logic [ecal_pkg::MONTH_W-1:0]  out_month,
  output logic [ecal_pkg::DAY_W-1:0]    out_day_of_month,
  output logic [ecal_pkg::HOUR_W-1:0]   out_hour,
  output logic [ecal_pkg::MIN_W-1:0]    out_minute,
  output logic [ecal_pkg::SEC_W-1:0]    out_second,
  output logic [1:0]                    out_status
);
  import ecal_pkg::*;

  localparam int CNT_W = $clog2(YEAR_SPAN + 1);
  localparam logic [CNT_W-1:0] SPAN_LIMIT = CNT_W'(YEAR_SPAN);

  // sequencer
  state_t state_r, state_nxt;

  // bias register
  logic signed [BIAS_W-1:0] bias_r, bias_nxt;

  // working registers
  logic [T_W-1:0]     t_r, t_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [6:0]         mod100_r, mod100_nxt;
  logic [8:0]         mod400_r, mod400_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [MIN_W-1:0]   minute_r, minute_nxt;
  status_t            status_r, status_nxt;

  // shared unit
  logic [T_W-1:0] operand;
  logic [T_W-1:0] diff;
  logic           ge;

  logic           leap;
  logic [T_W:0]   adj;
  logic           adj_neg;

  ecal_sub_unit #(.W(T_W)) u_sub (
    .minuend    (t_r),
    .subtrahend (operand),
    .diff       (diff),
    .ge         (ge)
  );

  // Gregorian rule from running residues: divisible by 4, and not by 100
  // unless also by 400.
  assign leap = (year_r[1:0] == 2'b00) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));

  // Subtract the sign-extended bias from the zero-extended input.
  assign adj     = {1'b0, {(T_W - EPOCH_W){1'b0}}, in_epoch_seconds}
                 - {{(T_W + 1 - BIAS_W){bias_r[BIAS_W-1]}}, bias_r};
  assign adj_neg = adj[T_W];

  // Pick what the shared unit takes off in each step.
  always_comb begin
    case (state_r)
      S_YEAR:  operand = leap ? SECS_LEAPYEAR : SECS_YEAR;
      S_MONTH: operand = T_W'(month_secs(leap, month_r));
      S_DAY:   operand = SECS_DAY;
      S_HOUR:  operand = SECS_HOUR;
      S_MIN:   operand = SECS_MIN;
      default: operand = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = adj_neg ? S_DONE : S_YEAR;
      S_YEAR: begin
        if (count_r == SPAN_LIMIT) state_nxt = S_DONE;
        else if (!ge)              state_nxt = S_MONTH;
      end
      S_MONTH: if (month_r == LAST_MONTH || !ge) state_nxt = S_DAY;
      S_DAY:   if (!ge) state_nxt = S_HOUR;
      S_HOUR:  if (!ge) state_nxt = S_MIN;
      S_MIN:   if (!ge) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: strobe the result in the done cycle; zero fields on error.
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    cfg_ready = 1'b1;
    out_status = status_r;
    if (status_r == ST_OK) begin
      out_year         = year_r;
      out_month        = month_r;
      out_day_of_month = day_r;
      out_hour         = hour_r;
      out_minute       = minute_r;
      out_second       = t_r[SEC_W-1:0];
    end else begin
      out_year         = '0;
      out_month        = '0;
      out_day_of_month = '0;
      out_hour         = '0;
      out_minute       = '0;
      out_second       = '0;
    end
  end

  // Datapath: hold by default, advance one step per cycle.
  always_comb begin
    bias_nxt   = bias_r;
    t_nxt      = t_r;
    year_nxt   = year_r;
    count_nxt  = count_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    status_nxt = status_r;

    if (cfg_valid && cfg_ready) bias_nxt = cfg_utc_bias_seconds;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          t_nxt      = adj[T_W-1:0];
          year_nxt   = BASE_YEAR;
          count_nxt  = '0;
          mod100_nxt = BASE_MOD100;
          mod400_nxt = BASE_MOD400;
          month_nxt  = '0;
          day_nxt    = DAY_W'(1);
          hour_nxt   = '0;
          minute_nxt = '0;
          status_nxt = adj_neg ? ST_BEFORE : ST_OK;
        end
      end
      S_YEAR: begin
        if (count_r == SPAN_LIMIT) begin
          status_nxt = ST_BEYOND;
        end else if (ge) begin
          t_nxt      = diff;
          year_nxt   = year_r + YEAR_W'(1);
          count_nxt  = count_r + CNT_W'(1);
          mod100_nxt = (mod100_r == 7'd99)  ? 7'd0 : mod100_r + 7'd1;
          mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
        end
      end
      S_MONTH: begin
        if (month_r != LAST_MONTH && ge) begin
          t_nxt     = diff;
          month_nxt = month_r + MONTH_W'(1);
        end
      end
      S_DAY: begin
        if (ge) begin
          t_nxt   = diff;
          day_nxt = day_r + DAY_W'(1);
        end
      end
      S_HOUR: begin
        if (ge) begin
          t_nxt    = diff;
          hour_nxt = hour_r + HOUR_W'(1);
        end
      end
      S_MIN: begin
        if (ge) begin
          t_nxt      = diff;
          minute_nxt = minute_r + MIN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bias_r  <= '0;
    end else begin
      state_r <= state_nxt;
      bias_r  <= bias_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    year_r   <= year_nxt;
    count_r  <= count_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    status_r <= status_nxt;
  end

endmodule
